FILE: design/mmts_pkg.sv
// Shared types and constants of the min/max tracking stack.
`timescale 1ns / 1ps
package mmts_pkg;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOAD = 2'b10
	} state_t;

	// One stack entry: its value and the running extremes of it and all below.
	typedef struct packed {
		logic signed [31:0] run_min;
		logic signed [31:0] run_max;
		logic signed [31:0] value;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Result fields, last field in the lowest bits.
	typedef struct packed {
		logic [8:0]         entry_count;
		logic               is_empty;
		logic signed [31:0] stack_min;
		logic signed [31:0] stack_max;
		status_t            status;
		logic signed [31:0] popped_value;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);
	localparam int unsigned OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

FILE: design/mmts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mmts_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/min_max_tracking_stack.sv
// Top level of the min/max tracking stack: control, top-of-stack cache and result register.
//
//   Channel  | Direction | Signals                          | Contents
//   ---------+-----------+----------------------------------+-------------------------------
//   s_axis   | in        | tvalid, tready, tdata[31:0], tuser | one push or pop request
//   m_axis   | out       | tvalid, tready, tdata[111:0]     | one result per request
//
// A push, a refused push and a refused pop are answered from the idle state; a pop that leaves
// the stack non-empty also passes the load state, where the new top entry returns from the RAM.
// The top entry is held in registers, so only such a pop reads the RAM.
// Reset empties the stack at once; the RAM needs no clearing pass.
// A stalled result waits in the output register and blocks new requests until taken.
`timescale 1ns / 1ps
module min_max_tracking_stack
	import mmts_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,  // push_value
	input  logic                  s_axis_tuser,  // op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// popped_value, status, stack_max, stack_min, is_empty, entry_count, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t           state_q, state_d;
	logic [CW-1:0]    fill_q, fill_d;
	logic             out_valid_q, out_valid_d;
	result_t          res_q, res_d;
	entry_t           top_q, top_d, new_entry, rd_entry;
	logic             load_top;
	logic signed [31:0] popped_q;
	logic             load_popped;
	logic [ENTRY_W-1:0] rdata;
	logic             in_fire, out_free, fill_zero, fill_full, fill_one;
	logic             ram_we, ram_re;
	logic signed [31:0] push_val;
	op_t              op;

	assign push_val  = s_axis_tdata;
	assign op        = op_t'(s_axis_tuser);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign fill_zero = (fill_q == '0);
	assign fill_one  = (fill_q == CW'(1));
	assign fill_full = (fill_q == CW'(DEPTH));
	assign rd_entry  = entry_t'(rdata);

	always_comb begin
		new_entry.value   = push_val;
		new_entry.run_max = (fill_zero || (push_val > top_q.run_max)) ? push_val : top_q.run_max;
		new_entry.run_min = (fill_zero || (push_val < top_q.run_min)) ? push_val : top_q.run_min;
	end

	assign ram_we = in_fire && (op == OP_PUSH) && !fill_full;
	assign ram_re = in_fire && (op == OP_POP) && !fill_zero && !fill_one;

	mmts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(fill_q)),
		.wdata(new_entry),
		.re   (ram_re),
		.raddr(AW'(fill_q - CW'(2))),
		.rdata(rdata)
	);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		res_d       = res_q;
		top_d       = top_q;
		load_top    = 1'b0;
		load_popped = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					res_d.popped_value = '0;
					res_d.status       = STAT_OK;
					if (op == OP_PUSH) begin
						if (fill_full) begin
							res_d.status      = STAT_FULL;
							res_d.stack_max   = top_q.run_max;
							res_d.stack_min   = top_q.run_min;
							res_d.is_empty    = 1'b0;
							res_d.entry_count = 9'(fill_q);
						end else begin
							fill_d            = fill_q + CW'(1);
							top_d             = new_entry;
							load_top          = 1'b1;
							res_d.stack_max   = new_entry.run_max;
							res_d.stack_min   = new_entry.run_min;
							res_d.is_empty    = 1'b0;
							res_d.entry_count = 9'(fill_q + CW'(1));
						end
						out_valid_d = 1'b1;
					end else if (fill_zero) begin
						res_d.status      = STAT_EMPTY;
						res_d.stack_max   = INT_MIN;
						res_d.stack_min   = INT_MAX;
						res_d.is_empty    = 1'b1;
						res_d.entry_count = '0;
						out_valid_d       = 1'b1;
					end else begin
						fill_d = fill_q - CW'(1);
						if (fill_one) begin
							res_d.popped_value = top_q.value;
							res_d.stack_max    = INT_MIN;
							res_d.stack_min    = INT_MAX;
							res_d.is_empty     = 1'b1;
							res_d.entry_count  = '0;
							out_valid_d        = 1'b1;
						end else begin
							load_popped = 1'b1;
							state_d     = ST_LOAD;
						end
					end
				end
			end
			ST_LOAD: begin
				top_d              = rd_entry;
				load_top           = 1'b1;
				res_d.popped_value = popped_q;
				res_d.status       = STAT_OK;
				res_d.stack_max    = rd_entry.run_max;
				res_d.stack_min    = rd_entry.run_min;
				res_d.is_empty     = 1'b0;
				res_d.entry_count  = 9'(fill_q);
				out_valid_d        = 1'b1;
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (load_top) begin
			top_q <= top_d;
		end
		if (load_popped) begin
			popped_q <= top_q.value;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, res_q};

endmodule
